// ----- src/slru_pkg.sv -----
// Shared types and constants for the size-aware LRU replacer.
package slru_pkg;

  localparam int unsigned Slots     = 64;
  localparam int unsigned IdxW      = $clog2(Slots);
  localparam int unsigned CntW      = $clog2(Slots + 1);
  localparam int unsigned KeyW      = 32;
  localparam int unsigned LenW      = 24;
  localparam int unsigned StatW     = 2;
  localparam int unsigned SlotOutW  = 6;
  localparam int unsigned EvW       = 7;
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 40;

  localparam logic [StatW-1:0] StatOk     = 2'd0;
  localparam logic [StatW-1:0] StatMiss   = 2'd1;
  localparam logic [StatW-1:0] StatReject = 2'd2;

  localparam logic RegCapacity = 1'b0;
  localparam logic RegMinEntry = 1'b1;

  localparam logic [LenW-1:0] CapacityReset = 24'd1048576;
  localparam logic [LenW-1:0] MinEntryReset = 24'd16384;

  typedef enum logic [2:0] {
    StIdle,
    StLook,
    StDecide,
    StCheck,
    StRead,
    StFree,
    StInsert,
    StDone
  } state_e;

  typedef struct packed {
    logic load;
    logic lookup;
    logic touch;
    logic pick;
    logic pick_lru;
    logic rd;
    logic free;
    logic insert;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_set;
    logic reject;
    logic hit;
    logic over;
    logic full;
    logic out_free;
  } stat_t;

endpackage

// ----- src/slru_ctrl.sv -----
// Controller state machine sequencing lookup, eviction and insert.
module slru_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  slru_pkg::stat_t st_i,
  output logic           in_ready_o,
  output slru_pkg::cmd_t cmd_o
);
  import slru_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_fire_i) state_d = StLook;
      StLook:   state_d = StDecide;
      StDecide: begin
        if (!st_i.is_set || st_i.reject) state_d = StDone;
        else if (st_i.hit) state_d = StRead;
        else state_d = StCheck;
      end
      StCheck:  begin
        if (st_i.over || st_i.full) state_d = StRead;
        else state_d = StInsert;
      end
      StRead:   state_d = StFree;
      StFree:   state_d = StCheck;
      StInsert: state_d = StDone;
      StDone:   if (st_i.out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle:   begin
        in_ready_o = 1'b1;
        cmd_o.load = in_fire_i;
      end
      StLook:   cmd_o.lookup = 1'b1;
      StDecide: begin
        cmd_o.touch = !st_i.is_set && st_i.hit;
        cmd_o.pick  = st_i.is_set && !st_i.reject && st_i.hit;
      end
      StCheck:  begin
        cmd_o.pick     = st_i.over || st_i.full;
        cmd_o.pick_lru = 1'b1;
      end
      StRead:   cmd_o.rd = 1'b1;
      StFree:   cmd_o.free = 1'b1;
      StInsert: cmd_o.insert = 1'b1;
      StDone:   cmd_o.finish = st_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

// ----- src/slru_dp.sv -----
// Datapath: tag table, recency ranks, size memory, byte total and result register.
module slru_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  slru_pkg::cmd_t               cmd_i,
  output slru_pkg::stat_t              st_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [slru_pkg::LenW-1:0]    cfg_data_i,
  input  logic                         req_type_i,
  input  logic [slru_pkg::KeyW-1:0]    key_tag_i,
  input  logic [slru_pkg::LenW-1:0]    value_len_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [slru_pkg::StatW-1:0]   status_o,
  output logic [slru_pkg::SlotOutW-1:0] slot_index_o,
  output logic [slru_pkg::EvW-1:0]     evicted_count_o,
  output logic [slru_pkg::LenW-1:0]    bytes_in_use_o
);
  import slru_pkg::*;

  logic [LenW-1:0] cap_q, min_q, total_q;
  logic [KeyW-1:0] key_q [Slots];
  logic [IdxW-1:0] rank_q [Slots];
  logic [Slots-1:0] used_q;
  logic [LenW-1:0] bytes_mem [Slots];
  logic [LenW-1:0] rdata_q;
  logic [CntW-1:0] count_q;

  logic            is_set_q, reject_q, hit_q, evflag_q;
  logic [KeyW-1:0] tag_q;
  logic [LenW-1:0] len_q;
  logic [IdxW-1:0] hit_idx_q, victim_q, slot_q;
  logic [StatW-1:0] status_q;
  logic [EvW-1:0]  evicted_q;

  logic            out_valid_q;
  logic [StatW-1:0] o_status_q;
  logic [SlotOutW-1:0] o_slot_q;
  logic [EvW-1:0]  o_ev_q;
  logic [LenW-1:0] o_bytes_q;

  logic [Slots-1:0] match, lru_hot;
  logic            match_any, free_any;
  logic [IdxW-1:0] match_idx, lru_idx, free_idx;
  logic [IdxW-1:0] last_rank, touch_rank, vic_rank;
  logic [LenW:0]   sum;

  assign last_rank  = IdxW'(count_q - CntW'(1));
  assign touch_rank = rank_q[hit_idx_q];
  assign vic_rank   = rank_q[victim_q];
  assign sum        = {1'b0, total_q} + {1'b0, len_q};

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    lru_idx   = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      match[i]   = used_q[i] && (key_q[i] == tag_q);
      lru_hot[i] = used_q[i] && (rank_q[i] == last_rank);
      if (match[i]) begin
        match_any = 1'b1;
        match_idx = IdxW'(i);
      end
      if (lru_hot[i]) lru_idx = IdxW'(i);
      if (!used_q[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign st_o.is_set   = is_set_q;
  assign st_o.reject   = reject_q;
  assign st_o.hit      = hit_q;
  assign st_o.over     = (count_q != '0) && (sum > {1'b0, cap_q});
  assign st_o.full     = !free_any;
  assign st_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapacityReset;
      min_q       <= MinEntryReset;
      total_q     <= '0;
      used_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegCapacity) cap_q <= cfg_data_i;
        else min_q <= cfg_data_i;
      end
      if (cmd_i.free) begin
        used_q[victim_q] <= 1'b0;
        total_q          <= total_q - rdata_q;
        count_q          <= count_q - CntW'(1);
      end
      if (cmd_i.insert) begin
        used_q[free_idx] <= 1'b1;
        total_q          <= sum[LenW-1:0];
        count_q          <= count_q + CntW'(1);
      end
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Slots; i++) begin
      if (cmd_i.touch && used_q[i]) begin
        if (IdxW'(i) == hit_idx_q) rank_q[i] <= '0;
        else if (rank_q[i] < touch_rank) rank_q[i] <= rank_q[i] + IdxW'(1);
      end
      if (cmd_i.free && used_q[i] && rank_q[i] > vic_rank) begin
        rank_q[i] <= rank_q[i] - IdxW'(1);
      end
      if (cmd_i.insert) begin
        if (IdxW'(i) == free_idx) rank_q[i] <= '0;
        else if (used_q[i]) rank_q[i] <= rank_q[i] + IdxW'(1);
      end
    end
    if (cmd_i.insert) begin
      key_q[free_idx]     <= tag_q;
      bytes_mem[free_idx] <= len_q;
      slot_q              <= free_idx;
      status_q            <= StatOk;
    end
    if (cmd_i.rd) rdata_q <= bytes_mem[victim_q];
    if (cmd_i.load) begin
      is_set_q  <= req_type_i;
      tag_q     <= key_tag_i;
      len_q     <= value_len_i;
      reject_q  <= (value_len_i < min_q) || (value_len_i > cap_q);
      evicted_q <= '0;
      slot_q    <= '0;
      status_q  <= req_type_i ? StatReject : StatMiss;
    end
    if (cmd_i.lookup) begin
      hit_q     <= match_any;
      hit_idx_q <= match_idx;
      if (!is_set_q && match_any) begin
        status_q <= StatOk;
        slot_q   <= match_idx;
      end
    end
    if (cmd_i.pick) begin
      victim_q <= cmd_i.pick_lru ? lru_idx : hit_idx_q;
      evflag_q <= cmd_i.pick_lru;
    end
    if (cmd_i.free && evflag_q && evicted_q != {EvW{1'b1}}) evicted_q <= evicted_q + EvW'(1);
    if (cmd_i.finish) begin
      o_status_q <= status_q;
      o_slot_q   <= SlotOutW'(slot_q);
      o_ev_q     <= evicted_q;
      o_bytes_q  <= total_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign slot_index_o    = o_slot_q;
  assign evicted_count_o = o_ev_q;
  assign bytes_in_use_o  = o_bytes_q;

endmodule

// ----- src/size_aware_lru_replacer.sv -----
// Top level of the size-aware LRU replacer.
//  Channel | Direction | Handshake              | Content
//  s_axis  | in        | tvalid/tready          | tdata key,len; tuser req_type
//  m_axis  | out       | tvalid/tready          | tdata status,slot,evicted,bytes
//  cfg     | in        | cfg_valid_i/cfg_ready_o | register index and data
// A get or a rejected set passes through lookup and decide before its result is loaded; a
// stored set also frees entries (tag repair and each eviction), each by a size memory read
// and then a free, before its insert. The input is taken again in the cycle after the result is loaded.
// One transaction is in work at a time; a finished result waits in the
// output register while the next transaction is taken.
// Reset clears the table valid bits, byte total and registers to defaults.
module size_aware_lru_replacer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [slru_pkg::InDataW-1:0]    s_axis_tdata,  // key_tag, value_len
  input  logic                            s_axis_tuser,  // req_type
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [slru_pkg::OutDataW-1:0]   m_axis_tdata,  // status, slot_index, evicted_count, bytes_in_use
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [slru_pkg::LenW-1:0]       cfg_data_i
);
  import slru_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  in_fire;
  logic [StatW-1:0]    status;
  logic [SlotOutW-1:0] slot_index;
  logic [EvW-1:0]      evicted_count;
  logic [LenW-1:0]     bytes_in_use;

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  slru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .st_i       (st),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  slru_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (s_axis_tuser),
    .key_tag_i       (s_axis_tdata[31:0]),
    .value_len_i     (s_axis_tdata[55:32]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .status_o        (status),
    .slot_index_o    (slot_index),
    .evicted_count_o (evicted_count),
    .bytes_in_use_o  (bytes_in_use)
  );

  assign m_axis_tdata = {1'b0, bytes_in_use, evicted_count, slot_index, status};

endmodule
